// ----- hw/rtl/canopy_vertical_turbulence_profile_unit_assert.svh -----
// assertion macros for the canopy vertical turbulence profile unit
// expects clk and rst in the scope of each use
`ifndef CANOPY_VERTICAL_TURBULENCE_PROFILE_UNIT_ASSERT_SVH
`define CANOPY_VERTICAL_TURBULENCE_PROFILE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define CVTP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// same-cycle implication
`define CVTP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CVTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cvtp_pkg.sv -----
// shared widths, codes and config type of the canopy turbulence profile unit
// no dependencies
`default_nettype none

package cvtp_pkg;

  localparam int DATA_W     = 16;
  localparam int REGION_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int ROOT_W     = 16;
  localparam int RAD_W      = 3 * ROOT_W;
  localparam int FRAC_SHIFT = 30;

  localparam logic [REGION_W-1:0] REGION_CUBE_ROOT       = 3'd0;
  localparam logic [REGION_W-1:0] REGION_BLEND_TOP       = 3'd1;
  localparam logic [REGION_W-1:0] REGION_ABOVE           = 3'd2;
  localparam logic [REGION_W-1:0] REGION_UNSTABLE_CANOPY = 3'd3;
  localparam logic [REGION_W-1:0] REGION_NEUTRAL_CANOPY  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_STABILITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CANOPY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLACEMENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONVECTIVE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECORR       = 3'd6;

  localparam logic signed [DATA_W-1:0] UNSTABLE_LIMIT = -16'sd200;
  localparam logic [DATA_W-1:0] CANOPY_RESET = 16'd64;
  localparam logic [DATA_W-1:0] DECORR_RESET = 16'd32768;

  typedef struct packed {
    logic signed [DATA_W-1:0] stability_length;
    logic [DATA_W-1:0]        blend_height;
    logic [DATA_W-1:0]        canopy_height;
    logic [DATA_W-1:0]        displacement_height;
    logic [DATA_W-1:0]        convective_constant;
    logic [DATA_W-1:0]        vertical_deviation;
    logic [DATA_W-1:0]        vertical_decorrelation;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cvtp_cfg_if.sv -----
// configuration write channel
// depends on cvtp_pkg
`default_nettype none

interface cvtp_cfg_if
  import cvtp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cvtp_sample_if.sv -----
// particle height input channel
// depends on cvtp_pkg
`default_nettype none

interface cvtp_sample_if
  import cvtp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cvtp_result_if.sv -----
// profile result channel
// depends on cvtp_pkg
`default_nettype none

interface cvtp_result_if
  import cvtp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   vertical_forcing_scale;
  logic [DATA_W-1:0]   variance_gradient;
  logic [REGION_W-1:0] profile_region;

  modport source (output valid, output vertical_forcing_scale, output variance_gradient,
                  output profile_region, input ready);
  modport sink (input valid, input vertical_forcing_scale, input variance_gradient,
                input profile_region, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cvtp_cfg_regs.sv -----
// configuration register file of the canopy turbulence profile unit
// depends on cvtp_pkg and cvtp_cfg_if
`default_nettype none

module cvtp_cfg_regs import cvtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cvtp_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stability_length       <= '0;
      regs.blend_height           <= '0;
      regs.canopy_height          <= CANOPY_RESET;
      regs.displacement_height    <= '0;
      regs.convective_constant    <= '0;
      regs.vertical_deviation     <= '0;
      regs.vertical_decorrelation <= DECORR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_STABILITY:    regs.stability_length       <= $signed(cfg.data);
        CFG_BLEND:        regs.blend_height           <= cfg.data;
        CFG_CANOPY:       regs.canopy_height          <= cfg.data;
        CFG_DISPLACEMENT: regs.displacement_height    <= cfg.data;
        CFG_CONVECTIVE:   regs.convective_constant    <= cfg.data;
        CFG_DEVIATION:    regs.vertical_deviation     <= cfg.data;
        CFG_DECORR:       regs.vertical_decorrelation <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cvtp_cbrt.sv -----
// pipelined integer cube root, one root bit per register stage
// depends on cvtp_pkg
`default_nettype none

module cvtp_cbrt import cvtp_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  radicand,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int STEPS = ROOT_W;
  localparam int Y2_W  = 2 * ROOT_W;
  localparam int B_W   = 2 * ROOT_W + 3;

  logic [STEPS-1:0]  v;
  logic [RAD_W-1:0]  rem [STEPS];
  logic [ROOT_W-1:0] y [STEPS];
  logic [Y2_W-1:0]   y2 [STEPS];
  logic [TAG_W-1:0]  tag [STEPS];

  logic [RAD_W-1:0]  rem_p [STEPS];
  logic [ROOT_W-1:0] y_p [STEPS];
  logic [Y2_W-1:0]   y2_p [STEPS];
  logic [ROOT_W-1:0] yd [STEPS];
  logic [Y2_W-1:0]   y2d [STEPS];
  logic [B_W-1:0]    b [STEPS];
  logic              take [STEPS];
  logic [RAD_W-1:0]  rem_n [STEPS];
  logic [ROOT_W-1:0] y_n [STEPS];
  logic [Y2_W-1:0]   y2_n [STEPS];

  always_comb begin
    rem_p[0] = radicand;
    y_p[0]   = '0;
    y2_p[0]  = '0;
    for (int i = 1; i < STEPS; i++) begin
      rem_p[i] = rem[i-1];
      y_p[i]   = y[i-1];
      y2_p[i]  = y2[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      // y doubles, trial term is 3*y*(y+1)+1 at this digit
      yd[i]  = y_p[i] << 1;
      y2d[i] = y2_p[i] << 2;
      b[i]   = (B_W'(y2d[i]) << 1) + B_W'(y2d[i]) + (B_W'(yd[i]) << 1) + B_W'(yd[i])
               + B_W'(1);
      take[i]  = (rem_p[i] >> (3 * (STEPS - 1 - i))) >= RAD_W'(b[i]);
      rem_n[i] = take[i] ? rem_p[i] - (RAD_W'(b[i]) << (3 * (STEPS - 1 - i))) : rem_p[i];
      y_n[i]   = yd[i] + ROOT_W'(take[i]);
      y2_n[i]  = take[i] ? y2d[i] + (Y2_W'(yd[i]) << 1) + Y2_W'(1) : y2d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      for (int i = 1; i < STEPS; i++) begin
        tag[i] <= tag[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
        rem[i] <= rem_n[i];
        y[i]   <= y_n[i];
        y2[i]  <= y2_n[i];
      end
    end
  end

  assign out_valid = v[STEPS-1];
  assign root      = y[STEPS-1];
  assign out_tag   = tag[STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cvtp_div.sv -----
// pipelined saturating divider, 16-bit quotient, one quotient bit per stage
// depends on cvtp_pkg
`default_nettype none

module cvtp_div import cvtp_pkg::*; #(
  parameter int N_W   = 36,
  parameter int D_W   = 20,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    num,
  input  logic [D_W-1:0]    den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [DATA_W-1:0] quotient,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int STEPS = DATA_W;
  localparam int CW    = (N_W > D_W + DATA_W) ? N_W : D_W + DATA_W;

  logic [STEPS-1:0]  v;
  logic [CW-1:0]     rem [STEPS];
  logic [D_W-1:0]    dv [STEPS];
  logic [DATA_W-1:0] q [STEPS];
  logic              ovf [STEPS];
  logic [TAG_W-1:0]  tag [STEPS];

  logic [CW-1:0]     rem_p [STEPS];
  logic [D_W-1:0]    d_p [STEPS];
  logic [DATA_W-1:0] q_p [STEPS];
  logic              take [STEPS];
  logic [CW-1:0]     dsh [STEPS];
  logic [CW-1:0]     rem_n [STEPS];
  logic [DATA_W-1:0] q_n [STEPS];
  logic              ovf_in;

  always_comb begin
    // quotient does not fit in 16 bits
    ovf_in   = CW'(num) >= (CW'(den) << DATA_W);
    rem_p[0] = CW'(num);
    d_p[0]   = den;
    q_p[0]   = '0;
    for (int i = 1; i < STEPS; i++) begin
      rem_p[i] = rem[i-1];
      d_p[i]   = dv[i-1];
      q_p[i]   = q[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      dsh[i]   = CW'(d_p[i]) << (STEPS - 1 - i);
      take[i]  = rem_p[i] >= dsh[i];
      rem_n[i] = take[i] ? rem_p[i] - dsh[i] : rem_p[i];
      q_n[i]   = q_p[i] | (DATA_W'(take[i]) << (STEPS - 1 - i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0] <= ovf_in;
      tag[0] <= in_tag;
      for (int i = 1; i < STEPS; i++) begin
        ovf[i] <= ovf[i-1];
        tag[i] <= tag[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
        rem[i] <= rem_n[i];
        dv[i]  <= d_p[i];
        q[i]   <= q_n[i];
      end
    end
  end

  assign out_valid = v[STEPS-1];
  assign quotient  = ovf[STEPS-1] ? '1 : q[STEPS-1];
  assign out_tag   = tag[STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/canopy_vertical_turbulence_profile_unit.sv -----
// canopy vertical turbulence profile unit, top level
// depends on cvtp_pkg, the channel interfaces, cvtp_cfg_regs, cvtp_cbrt, cvtp_div
//
// usage:
//   cfg    : register writes (index, data), always ready; write only while idle
//   sample : one particle height per transfer, Q10.6 m
//   result : forcing scale Q4.12, variance gradient Q6.10, region code
// every sample transfer yields exactly one result transfer, in order
// throughput: one sample per cycle, sustained
// latency: 53 cycles from sample transfer to result valid (input register,
//   16-stage cube root, two multiply stages, 16-stage ramp dividers, one
//   multiply stage, 16-stage gradient divider, output register)
// reset clears all pipeline valid bits and loads register defaults
//   (canopy height 1 m, decorrelation one, everything else zero)
// when the receiver stalls a waiting result, the whole pipeline holds and
//   sample.ready drops; nothing is lost or repeated
`default_nettype none
`include "canopy_vertical_turbulence_profile_unit_assert.svh"

module canopy_vertical_turbulence_profile_unit import cvtp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  cvtp_cfg_if.sink       cfg,
  cvtp_sample_if.sink    sample,
  cvtp_result_if.source  result
);

  localparam int T_W     = DATA_W + 4;
  localparam int N_W     = DATA_W + T_W;
  localparam int H1280_W = DATA_W + 11;
  localparam int PROD_W  = 2 * DATA_W;
  localparam logic [ROOT_W-1:0] ROOT_MIN = ROOT_W'(1) << (FRAC_SHIFT / 3);

  cfg_t regs;
  logic en;

  cvtp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // derived configuration
  logic signed [DATA_W-1:0] len;
  logic [DATA_W-1:0]  h_eff;
  logic               unstable;
  logic [T_W-1:0]     h10;
  logic [H1280_W-1:0] h1280;

  assign len      = regs.stability_length;
  assign h_eff    = (regs.canopy_height == '0) ? DATA_W'(1) : regs.canopy_height;
  assign unstable = (len < 16'sd0) && (len > UNSTABLE_LIMIT);
  assign h10      = (T_W'(h_eff) << 3) + (T_W'(h_eff) << 1);
  assign h1280    = (H1280_W'(h_eff) << 10) + (H1280_W'(h_eff) << 8);

  // input register
  logic              v_in;
  logic [DATA_W-1:0] z_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en) begin
      v_in <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_in <= sample.height;
    end
  end

  // region decision and root operand
  logic [REGION_W-1:0] region_in;
  logic [DATA_W-1:0]   top_in;
  logic [DATA_W:0]     diff_in;
  logic [DATA_W-1:0]   len_in;
  logic [RAD_W-1:0]    radicand;

  always_comb begin
    if (unstable && (z_in > regs.blend_height)) begin
      region_in = REGION_CUBE_ROOT;
    end else if (z_in > h_eff) begin
      region_in = unstable ? REGION_BLEND_TOP : REGION_ABOVE;
    end else begin
      region_in = unstable ? REGION_UNSTABLE_CANOPY : REGION_NEUTRAL_CANOPY;
    end
    top_in  = (region_in == REGION_CUBE_ROOT) ? z_in : regs.blend_height;
    diff_in = {1'b0, top_in} - {1'b0, regs.displacement_height};
    // non-positive length above displacement becomes one lsb
    len_in  = (diff_in[DATA_W] || diff_in == '0) ? DATA_W'(1) : diff_in[DATA_W-1:0];
    radicand = RAD_W'(len_in) << FRAC_SHIFT;
  end

  logic                       cb_valid;
  logic [ROOT_W-1:0]          cb_root;
  logic [REGION_W+DATA_W-1:0] cb_tag;

  cvtp_cbrt #(
    .TAG_W (REGION_W + DATA_W)
  ) u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_in),
    .radicand  (radicand),
    .in_tag    ({region_in, z_in}),
    .out_valid (cb_valid),
    .root      (cb_root),
    .out_tag   (cb_tag)
  );

  // stage m1: cube-root sigma, ramp factor, first divider operands
  logic [DATA_W-1:0]   z_c;
  logic [REGION_W-1:0] region_c;
  logic [T_W-1:0]      t_c;
  logic [PROD_W-1:0]   cr_c;
  logic [PROD_W-1:0]   cc_c;
  logic [N_W-1:0]      wt_c;
  logic [DATA_W-1:0]   s0_c;
  logic [T_W-1:0]      r6_c;

  always_comb begin
    {region_c, z_c} = cb_tag;
    t_c  = (T_W'(z_c) << 3) + T_W'(z_c) + T_W'(h_eff);
    cr_c = PROD_W'(regs.convective_constant) * PROD_W'(cb_root);
    cc_c = PROD_W'(regs.convective_constant) * PROD_W'(regs.convective_constant);
    wt_c = N_W'(regs.vertical_deviation) * N_W'(t_c);
    s0_c = (|cr_c[PROD_W-1:DATA_W+12]) ? '1 : cr_c[DATA_W+11:12];
    r6_c = (T_W'(cb_root) << 2) + (T_W'(cb_root) << 1);
  end

  logic                m1_v;
  logic [DATA_W-1:0]   m1_s0;
  logic [T_W-1:0]      m1_t;
  logic [N_W-1:0]      m1_numa;
  logic [T_W-1:0]      m1_dena;
  logic [REGION_W-1:0] m1_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= cb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_s0     <= s0_c;
      m1_t      <= t_c;
      m1_numa   <= (region_c == REGION_CUBE_ROOT) ? N_W'(cc_c) : wt_c;
      m1_dena   <= (region_c == REGION_CUBE_ROOT) ? r6_c : h10;
      m1_region <= region_c;
    end
  end

  // stage m2: unstable ramp numerator
  logic                m2_v;
  logic [DATA_W-1:0]   m2_s0;
  logic [N_W-1:0]      m2_numa;
  logic [T_W-1:0]      m2_dena;
  logic [N_W-1:0]      m2_numb;
  logic [REGION_W-1:0] m2_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (en) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_s0     <= m1_s0;
      m2_numa   <= m1_numa;
      m2_dena   <= m1_dena;
      m2_numb   <= N_W'(m1_s0) * N_W'(m1_t);
      m2_region <= m1_region;
    end
  end

  logic                da_v;
  logic [DATA_W-1:0]   qa;
  logic [REGION_W-1:0] da_region;
  logic                db_v;
  logic [DATA_W-1:0]   qb;
  logic [DATA_W-1:0]   db_s0;

  cvtp_div #(
    .N_W   (N_W),
    .D_W   (T_W),
    .TAG_W (REGION_W)
  ) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_v),
    .num       (m2_numa),
    .den       (m2_dena),
    .in_tag    (m2_region),
    .out_valid (da_v),
    .quotient  (qa),
    .out_tag   (da_region)
  );

  cvtp_div #(
    .N_W   (N_W),
    .D_W   (T_W),
    .TAG_W (DATA_W)
  ) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_v),
    .num       (m2_numb),
    .den       (h10),
    .in_tag    (m2_s0),
    .out_valid (db_v),
    .quotient  (qb),
    .out_tag   (db_s0)
  );

  // stage m3: sigma selection and gradient numerator
  logic [DATA_W-1:0] sigw_c;
  logic [PROD_W-1:0] sw_c;

  always_comb begin
    case (da_region) inside
      REGION_CUBE_ROOT, REGION_BLEND_TOP: sigw_c = db_s0;
      REGION_ABOVE:                       sigw_c = regs.vertical_deviation;
      REGION_UNSTABLE_CANOPY:             sigw_c = qb;
      default:                            sigw_c = qa;
    endcase
    sw_c = PROD_W'(qa) * PROD_W'(regs.vertical_deviation);
  end

  logic                m3_v;
  logic [DATA_W-1:0]   m3_sigw;
  logic [N_W-1:0]      m3_numc;
  logic [DATA_W-1:0]   m3_grada;
  logic [REGION_W-1:0] m3_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (en) begin
      m3_v <= da_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_sigw   <= sigw_c;
      m3_numc   <= (N_W'(sw_c) << 3) + N_W'(sw_c);
      m3_grada  <= qa;
      m3_region <= da_region;
    end
  end

  logic                              dc_v;
  logic [DATA_W-1:0]                 qc;
  logic [REGION_W+2*DATA_W-1:0]      dc_tag;
  logic [REGION_W-1:0]               dc_region;
  logic [DATA_W-1:0]                 dc_grada;
  logic [DATA_W-1:0]                 dc_sigw;

  cvtp_div #(
    .N_W   (N_W),
    .D_W   (H1280_W),
    .TAG_W (REGION_W + 2 * DATA_W)
  ) u_div_c (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m3_v),
    .num       (m3_numc),
    .den       (h1280),
    .in_tag    ({m3_region, m3_grada, m3_sigw}),
    .out_valid (dc_v),
    .quotient  (qc),
    .out_tag   (dc_tag)
  );

  // output stage: decorrelation product and gradient selection
  logic [PROD_W-1:0] fs_prod;
  logic [DATA_W-1:0] fs_c;
  logic [DATA_W-1:0] grad_c;

  always_comb begin
    {dc_region, dc_grada, dc_sigw} = dc_tag;
    fs_prod = PROD_W'(regs.vertical_decorrelation) * PROD_W'(dc_sigw);
    fs_c    = (|fs_prod[PROD_W-1:DATA_W+15]) ? '1 : fs_prod[DATA_W+14:15];
    case (dc_region) inside
      REGION_CUBE_ROOT:               grad_c = dc_grada;
      REGION_BLEND_TOP, REGION_ABOVE: grad_c = '0;
      default:                        grad_c = qc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= dc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.vertical_forcing_scale <= fs_c;
      result.variance_gradient      <= grad_c;
      result.profile_region         <= dc_region;
    end
  end

  `CVTP_ASSERT_ALWAYS(a_div_lanes_aligned, da_v == db_v, "ramp divider lanes out of step")
  `CVTP_ASSERT_IMPL(a_root_floor, cb_valid, cb_root >= ROOT_MIN, "cube root below clamp floor")
  `CVTP_ASSERT_IMPL(a_flat_zero_gradient,
      result.valid && (result.profile_region == REGION_BLEND_TOP ||
      result.profile_region == REGION_ABOVE),
      result.variance_gradient == '0, "nonzero gradient above canopy")
  `CVTP_ASSERT_NEXT(a_stall_holds_stage, m1_v && !en, m1_v, "pipeline item dropped in stall")

endmodule

`default_nettype wire
